### src/vlafr_pkg.sv
// Package for the value list block: default sizes, field widths, command and status codes.
// Depends on nothing. Used by value_list_append_find_remove.sv.
`default_nettype none

package vlafr_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned DEFAULT_DEPTH      = 16;
  localparam int unsigned DEFAULT_WORD_WIDTH = 32;

  // Field widths of the two channels.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

endpackage

`default_nettype wire

### src/vlafr_store.sv
// Entry memory of the value list: one write port and one read port, read data registered.
// Depends on nothing; sizes arrive as parameters from the top level.
`default_nettype none

module vlafr_store #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [WORD_WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [WORD_WIDTH-1:0] rd_data
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  // Entries have no reset; only data of entries below the count is ever used.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/value_list_append_find_remove.sv
// Top level of the value list: command sequencer around the entry memory.
// Depends on vlafr_pkg (codes, widths, defaults) and vlafr_store (entry memory).
`default_nettype none

//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------------------
//  in_      | input     | in_valid / in_stall  | in_command, in_value, in_index
//  out_     | output    | out_valid / out_stall| out_status, out_position, out_read_value,
//           |           |                      | out_count
//
// One command is worked on at a time; the input accepts a beat only while the sequencer is idle,
// even if the previous result beat still waits in the output register.
// Clear, append, the spare codes and the errors answered at once (list full, index out of
// range, a search of an empty list) go from accept straight to the result state S_RESP; read
// passes through S_RDWAIT first. Find and remove walk the memory one entry per cycle through its
// single read port; a remove then shifts the later entries down at one per cycle. Reset is
// synchronous and clears only the count and the control state; the memory needs no clearing
// pass. A stalled output only delays the return to idle.

module value_list_append_find_remove #(
  parameter int unsigned DEPTH      = vlafr_pkg::DEFAULT_DEPTH,
  parameter int unsigned WORD_WIDTH = vlafr_pkg::DEFAULT_WORD_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [vlafr_pkg::CMD_W-1:0]        in_command,
  input  wire logic signed [vlafr_pkg::VALUE_W-1:0] in_value,
  input  wire logic [vlafr_pkg::INDEX_W-1:0]      in_index,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [vlafr_pkg::STAT_W-1:0]            out_status,
  output logic [vlafr_pkg::POS_W-1:0]             out_position,
  output logic signed [vlafr_pkg::VALUE_W-1:0]    out_read_value,
  output logic [vlafr_pkg::COUNT_W-1:0]           out_count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > vlafr_pkg::INDEX_W) ? CW : vlafr_pkg::INDEX_W;

  // S_SCAN compares the entry read last cycle; S_SHIFT writes it one place lower.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RDWAIT,
    S_RESP
  } state_t;

  state_t                        state_r;
  logic [CW-1:0]                 count_r;
  logic [AW-1:0]                 ptr_r;
  logic [WORD_WIDTH-1:0]         word_r;
  logic                          remove_r;
  vlafr_pkg::status_t            res_status_r;
  logic [vlafr_pkg::POS_W-1:0]   res_pos_r;
  logic [vlafr_pkg::VALUE_W-1:0] res_data_r;
  logic                          out_valid_r;
  logic [vlafr_pkg::STAT_W-1:0]  out_status_r;
  logic [vlafr_pkg::POS_W-1:0]   out_position_r;
  logic [vlafr_pkg::VALUE_W-1:0] out_read_value_r;
  logic [vlafr_pkg::COUNT_W-1:0] out_count_r;

  logic                  in_accept;
  logic                  out_free;
  vlafr_pkg::cmd_t       in_cmd;
  logic [WORD_WIDTH-1:0] in_word;
  logic [CW-1:0]         ptr_inc;
  logic [CW-1:0]         ptr_inc2;
  logic                  not_full;
  logic                  idx_ok;
  logic                  hit;

  logic                  mem_we;
  logic [AW-1:0]         mem_wr_addr;
  logic [WORD_WIDTH-1:0] mem_wr_data;
  logic [AW-1:0]         mem_rd_addr;
  logic [WORD_WIDTH-1:0] mem_rd_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_cmd    = vlafr_pkg::cmd_t'(in_command);

  // The 32-bit value is sign extended (or cut) to the stored word width.
  assign in_word   = WORD_WIDTH'(in_value);

  assign ptr_inc   = CW'(ptr_r) + CW'(1);
  assign ptr_inc2  = CW'(ptr_r) + CW'(2);
  assign not_full  = (count_r < CW'(DEPTH));
  assign idx_ok    = (IW'(in_index) < IW'(count_r));
  assign hit       = (mem_rd_data == word_r);

  // Memory port control. During a shift the write lands at ptr_r while the read fetches
  // ptr_r + 2, so the two ports never touch the same entry and no forwarding is needed.
  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = ptr_r;
    mem_wr_data = mem_rd_data;
    mem_rd_addr = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        mem_rd_addr = (in_cmd == vlafr_pkg::CMD_READ) ? AW'(in_index) : '0;
        if (in_accept && (in_cmd == vlafr_pkg::CMD_APPEND) && not_full) begin
          mem_we      = 1'b1;
          mem_wr_addr = AW'(count_r);
          mem_wr_data = in_word;
        end
      end
      S_SCAN: begin
        mem_rd_addr = AW'(ptr_inc);
      end
      S_SHIFT: begin
        mem_we      = 1'b1;
        mem_rd_addr = AW'(ptr_inc2);
      end
      default: begin
        mem_rd_addr = ptr_r;
      end
    endcase
  end

  vlafr_store #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_RESP the output register is reloaded below whenever it drains.
      if (out_valid_r && !out_stall && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            word_r       <= in_word;
            remove_r     <= (in_cmd == vlafr_pkg::CMD_REMOVE);
            ptr_r        <= '0;
            res_status_r <= vlafr_pkg::ST_OK;
            res_pos_r    <= '0;
            res_data_r   <= '0;
            unique case (in_cmd)
              vlafr_pkg::CMD_CLEAR: begin
                count_r <= '0;
                state_r <= S_RESP;
              end
              vlafr_pkg::CMD_APPEND: begin
                if (not_full) begin
                  count_r <= count_r + CW'(1);
                end else begin
                  res_status_r <= vlafr_pkg::ST_FULL;
                end
                state_r <= S_RESP;
              end
              vlafr_pkg::CMD_FIND, vlafr_pkg::CMD_REMOVE: begin
                if (count_r == '0) begin
                  res_status_r <= vlafr_pkg::ST_NOT_FOUND;
                  state_r      <= S_RESP;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              vlafr_pkg::CMD_READ: begin
                if (idx_ok) begin
                  state_r <= S_RDWAIT;
                end else begin
                  res_status_r <= vlafr_pkg::ST_RANGE;
                  state_r      <= S_RESP;
                end
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_pos_r <= vlafr_pkg::POS_W'(ptr_r);
            if (remove_r && (ptr_inc < count_r)) begin
              state_r <= S_SHIFT;
            end else begin
              if (remove_r) begin
                count_r <= count_r - CW'(1);
              end
              state_r <= S_RESP;
            end
          end else if (ptr_inc < count_r) begin
            ptr_r <= AW'(ptr_inc);
          end else begin
            res_status_r <= vlafr_pkg::ST_NOT_FOUND;
            state_r      <= S_RESP;
          end
        end
        S_SHIFT: begin
          if (ptr_inc2 < count_r) begin
            ptr_r <= AW'(ptr_inc);
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= S_RESP;
          end
        end
        S_RDWAIT: begin
          res_data_r <= vlafr_pkg::VALUE_W'(mem_rd_data);
          state_r    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_status_r     <= res_status_r;
            out_position_r   <= res_pos_r;
            out_read_value_r <= res_data_r;
            out_count_r      <= vlafr_pkg::COUNT_W'(count_r);
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_position   = out_position_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

`ifndef NO_ASSERTIONS
  // The count never grows past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds capacity");

  // A shift write never targets the entry being read in the same cycle.
  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (mem_wr_addr != mem_rd_addr))
    else $error("shift write and read hit the same entry");

  // An accepted clear empties the list by the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd == vlafr_pkg::CMD_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the list");

  // A full report only goes out while the list is at capacity.
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == vlafr_pkg::ST_FULL)) |->
      (out_count_r == vlafr_pkg::COUNT_W'(DEPTH)))
    else $error("full status with a list below capacity");

  // A scan only runs over entries below the count.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(ptr_r) < count_r))
    else $error("scan pointer beyond the count");
`endif

endmodule

`default_nettype wire
